// ----- hdl/gdn_pkg.sv -----
package gdn_pkg;

    localparam int unsigned DayW    = 5;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned InYearW = 14;
    localparam int unsigned YearW   = 16;
    localparam int unsigned SerialW = 24;

    // pipeline depth of both conversion paths
    localparam int unsigned Stages = 6;

    localparam logic CmdDateToSerial = 1'b0;
    localparam logic CmdSerialToDate = 1'b1;

    localparam logic [SerialW-1:0] SerialBase   = 24'd382;
    localparam logic [SerialW-1:0] SerialOffset = 24'd75;
    localparam logic [17:0]        Days400y     = 18'd146097;
    localparam logic [10:0]        Days4y       = 11'd1461;

    // reciprocals for the constant divides
    localparam logic [12:0] RecipDiv100  = 13'd5243;   // 2^19 / 100
    localparam logic [14:0] RecipDays400 = 15'd29398;  // 2^32 / 146097
    localparam logic [13:0] RecipDays4   = 14'd11483;  // 2^24 / 1461

    typedef struct packed {
        logic                 command;
        logic [DayW-1:0]      in_day;
        logic [MonthW-1:0]    in_month;
        logic [InYearW-1:0]   in_year;
        logic [SerialW-1:0]   in_serial;
    } t_item;

    typedef struct packed {
        logic                 ok;
        logic [SerialW-1:0]   serial;
    } t_d2s_res;

    typedef struct packed {
        logic                 ok;
        logic [DayW-1:0]      day;
        logic [MonthW-1:0]    month;
        logic [YearW-1:0]     year;
    } t_s2d_res;

    // days before each month of a march-based year
    function automatic logic [8:0] cum_days(input logic [3:0] mm);
        logic [8:0] v;
        case (mm)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // length of a calendar month, february in a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] v;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
            4'd2:                                        v = 5'd28;
            default:                                     v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/gdn_if.sv -----
interface gdn_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [gdn_pkg::DayW-1:0]       in_day;
    logic [gdn_pkg::MonthW-1:0]     in_month;
    logic [gdn_pkg::InYearW-1:0]    in_year;
    logic [gdn_pkg::SerialW-1:0]    in_serial;

    modport source (output valid, command, in_day, in_month, in_year, in_serial,
                    input ready);
    modport sink   (input valid, command, in_day, in_month, in_year, in_serial,
                    output ready);
endinterface

interface gdn_out_if;
    logic                           valid;
    logic                           ready;
    logic [gdn_pkg::SerialW-1:0]    out_serial;
    logic [gdn_pkg::DayW-1:0]       out_day;
    logic [gdn_pkg::MonthW-1:0]     out_month;
    logic [gdn_pkg::YearW-1:0]      out_year;
    logic                           valid_res;

    modport source (output valid, out_serial, out_day, out_month, out_year, valid_res,
                    input ready);
    modport sink   (input valid, out_serial, out_day, out_month, out_year, valid_res,
                    output ready);
endinterface

// ----- hdl/gregorian_day_number_converter_unit.sv -----
// channel   dir  handshake      payload
// i_in      in   valid/ready    command, in_day, in_month, in_year, in_serial
// o_out     out  valid/ready    out_serial, out_day, out_month, out_year, valid_res
//
// six register stages; one item can enter every cycle unless the output stalls
// both conversions run side by side; the command picks which one reports
// reset (synchronous, active low) clears only the stage valid bits
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
module gregorian_day_number_converter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdn_in_if.sink    i_in,
    gdn_out_if.source o_out
);
    import gdn_pkg::*;

    logic [Stages-1:0] r_vld;
    logic              pipe_en;
    t_item             item;
    t_d2s_res          d2s_res;
    t_s2d_res          s2d_res;

    // pipeline moves whenever the last stage is empty or being taken
    assign pipe_en    = !r_vld[Stages-1] || o_out.ready;
    assign i_in.ready = pipe_en;

    assign item.command   = i_in.command;
    assign item.in_day    = i_in.in_day;
    assign item.in_month  = i_in.in_month;
    assign item.in_year   = i_in.in_year;
    assign item.in_serial = i_in.in_serial;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[Stages-2:0], i_in.valid};
        end
    end

    gdn_d2s u_d2s (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_item (item),
        .o_res  (d2s_res)
    );

    gdn_s2d u_s2d (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_item (item),
        .o_res  (s2d_res)
    );

    // result merge
    assign o_out.valid      = r_vld[Stages-1];
    assign o_out.out_serial = d2s_res.serial;
    assign o_out.out_day    = s2d_res.day;
    assign o_out.out_month  = s2d_res.month;
    assign o_out.out_year   = s2d_res.year;
    assign o_out.valid_res  = d2s_res.ok || s2d_res.ok;

    // a good result fills exactly one of the two directions
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.valid_res |-> ((o_out.out_serial != '0) != (o_out.out_month != '0)))
        else $error("result carries both or neither direction");

    // a failed conversion reports all zeros
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.valid_res |->
            (o_out.out_serial == '0) && (o_out.out_day == '0) &&
            (o_out.out_month == '0) && (o_out.out_year == '0))
        else $error("failed conversion with nonzero fields");

    // a converted date has a real month and day
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.out_month != '0) |->
            (o_out.out_month <= 4'd12) && (o_out.out_day != '0) && (o_out.out_year != '0))
        else $error("converted date out of range");

endmodule

// ----- hdl/gdn_d2s.sv -----
module gdn_d2s (
    input  logic              i_clk,
    input  logic              i_en,
    input  gdn_pkg::t_item    i_item,
    output gdn_pkg::t_d2s_res o_res
);
    import gdn_pkg::*;

    logic                r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    logic [DayW-1:0]     r1_d, r2_d, r3_d, r4_d;
    logic [MonthW-1:0]   r1_m, r2_m;
    logic [3:0]          r1_mm, r2_mm, r3_mm, r4_mm;
    logic [InYearW-1:0]  r1_y, r2_y, r1_yy, r2_yy;
    logic [26:0]         r2_py, r2_pyy;
    logic [7:0]          r3_cyy;
    logic [6:0]          r3_rem;
    logic [25:0]         r4_a;
    logic [17:0]         r4_b;
    logic [SerialW-1:0]  r5_part;
    logic [9:0]          r5_add;
    t_d2s_res            r6_res;

    logic [7:0]          cy, cyy;
    logic                leap, day_ok;
    logic [4:0]          dim;
    logic [InYearW-1:0]  y_hund, yy_hund;

    // stage 3 combinational: leap check, date check, year split
    always_comb begin
        cy      = r2_py[26:19];
        cyy     = r2_pyy[26:19];
        y_hund  = InYearW'(cy * 7'd100);
        yy_hund = InYearW'(cyy * 7'd100);
        leap    = (r2_y[1:0] == 2'b00) && ((r2_y != y_hund) || (cy[1:0] == 2'b00));
        dim     = month_len(r2_m) + ((r2_m == 4'd2 && leap) ? 5'd1 : 5'd0);
        day_ok  = (r2_d != '0) && (r2_d <= dim) && (r2_y != '0) && (dim != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: march-based year and month
            r1_ok <= (i_item.command == CmdDateToSerial);
            r1_d  <= i_item.in_day;
            r1_m  <= i_item.in_month;
            r1_y  <= i_item.in_year;
            if (i_item.in_month > 4'd2) begin
                r1_yy <= i_item.in_year;
                r1_mm <= i_item.in_month - 4'd3;
            end else begin
                r1_yy <= i_item.in_year - InYearW'(1);
                r1_mm <= i_item.in_month + 4'd9;
            end
            // stage 2: reciprocal products for the century
            r2_ok  <= r1_ok;
            r2_d   <= r1_d;
            r2_m   <= r1_m;
            r2_mm  <= r1_mm;
            r2_y   <= r1_y;
            r2_yy  <= r1_yy;
            r2_py  <= r1_y * RecipDiv100;
            r2_pyy <= r1_yy * RecipDiv100;
            // stage 3
            r3_ok  <= r2_ok && day_ok;
            r3_d   <= r2_d;
            r3_mm  <= r2_mm;
            r3_cyy <= cyy;
            r3_rem <= 7'(r2_yy - yy_hund);
            // stage 4: day counts of whole centuries and years
            r4_ok  <= r3_ok;
            r4_d   <= r3_d;
            r4_mm  <= r3_mm;
            r4_a   <= 26'(r3_cyy * Days400y);
            r4_b   <= 18'(r3_rem * Days4y);
            // stage 5: partial sums
            r5_ok   <= r4_ok;
            r5_part <= r4_a[25:2] + SerialW'(r4_b[17:2]);
            r5_add  <= 10'(cum_days(r4_mm)) + 10'(r4_d) + 10'(SerialOffset);
            // stage 6: final sum
            r6_res.ok     <= r5_ok;
            r6_res.serial <= r5_ok ? (r5_part + SerialW'(r5_add)) : '0;
        end
    end

    assign o_res = r6_res;

endmodule

// ----- hdl/gdn_s2d.sv -----
module gdn_s2d (
    input  logic              i_clk,
    input  logic              i_en,
    input  gdn_pkg::t_item    i_item,
    output gdn_pkg::t_s2d_res o_res
);
    import gdn_pkg::*;

    logic                r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    logic [25:0]         r1_n;
    logic [40:0]         r1_p;
    logic [8:0]          r2_c0;
    logic [18:0]         r2_t;
    logic [8:0]          r3_c, r4_c, r5_c;
    logic [17:0]         r3_x;
    logic [31:0]         r3_p;
    logic [7:0]          r4_yc0;
    logic [11:0]         r4_t;
    logic [7:0]          r5_yc;
    logic [8:0]          r5_dd;
    t_s2d_res            r6_res;

    logic [25:0]         s_adj;
    logic [26:0]         t_full;
    logic [18:0]         t_fix;
    logic [8:0]          c_fix;
    logic [18:0]         t2_full;
    logic [11:0]         t2_fix;
    logic [7:0]          yc_fix;
    logic [3:0]          mm;
    logic [YearW-1:0]    yr;

    always_comb begin
        s_adj  = 26'(i_item.in_serial - SerialOffset);
        // stage 2: remainder after the century estimate
        t_full = 27'(r1_n) - 27'(r1_p[40:32] * Days400y);
        // stage 3: fix the century estimate
        if (r2_t >= 19'(Days400y)) begin
            t_fix = r2_t - 19'(Days400y);
            c_fix = r2_c0 + 9'd1;
        end else begin
            t_fix = r2_t;
            c_fix = r2_c0;
        end
        // stage 4: remainder after the year estimate
        t2_full = 19'(r3_x) - 19'(r3_p[31:24] * Days4y);
        // stage 5: fix the year estimate
        if (r4_t >= 12'(Days4y)) begin
            t2_fix = r4_t - 12'(Days4y);
            yc_fix = r4_yc0 + 8'd1;
        end else begin
            t2_fix = r4_t;
            yc_fix = r4_yc0;
        end
        // stage 6: month search over the start-of-month table
        mm = '0;
        for (int k = 1; k < 12; k++) begin
            if (r5_dd > cum_days(4'(k))) begin
                mm = 4'(k);
            end
        end
        yr = YearW'(r5_c * 7'd100) + YearW'(r5_yc) + ((mm >= 4'd10) ? 16'd1 : 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: scaled day count and century reciprocal product
            r1_ok <= (i_item.command == CmdSerialToDate) && (i_item.in_serial >= SerialBase);
            r1_n  <= {s_adj[23:0], 2'b00} - 26'd1;
            r1_p  <= ({s_adj[23:0], 2'b00} - 26'd1) * RecipDays400;
            r2_ok <= r1_ok;
            r2_c0 <= r1_p[40:32];
            r2_t  <= t_full[18:0];
            r3_ok <= r2_ok;
            r3_c  <= c_fix;
            r3_x  <= {t_fix[17:2], 2'b11};
            r3_p  <= {t_fix[17:2], 2'b11} * RecipDays4;
            r4_ok <= r3_ok;
            r4_c  <= r3_c;
            r4_yc0 <= r3_p[31:24];
            r4_t  <= t2_full[11:0];
            r5_ok <= r4_ok;
            r5_c  <= r4_c;
            r5_yc <= yc_fix;
            r5_dd <= 9'((13'(t2_fix) + 13'd4) >> 2);
            r6_res.ok <= r5_ok;
            if (r5_ok) begin
                r6_res.day   <= DayW'(r5_dd - cum_days(mm));
                r6_res.month <= (mm < 4'd10) ? (mm + 4'd3) : (mm - 4'd9);
                r6_res.year  <= yr;
            end else begin
                r6_res.day   <= '0;
                r6_res.month <= '0;
                r6_res.year  <= '0;
            end
        end
    end

    assign o_res = r6_res;

endmodule
